FILE: src/efd_pkg.sv
// package: shared types, constants and the crc-16 byte update for the frame receiver
`timescale 1ns / 1ps

package efd_pkg;

  // parser phases
  typedef enum logic [2:0] {
    PH_WAIT    = 3'd0,
    PH_TYPE    = 3'd1,
    PH_SEQ     = 3'd2,
    PH_LENLO   = 3'd3,
    PH_LENHI   = 3'd4,
    PH_PAYLOAD = 3'd5,
    PH_CRCLO   = 3'd6,
    PH_CRCHI   = 3'd7
  } phase_e;

  // result kinds
  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_GOOD  = 2'd1,
    KIND_BAD   = 2'd2,
    KIND_ABORT = 2'd3
  } kind_e;

  // configuration register indexes
  localparam logic CFG_START  = 1'b0;
  localparam logic CFG_ESCAPE = 1'b1;

  localparam logic [7:0]  StartReset  = 8'hAA;
  localparam logic [7:0]  EscapeReset = 8'hBB;
  localparam logic [15:0] CrcInit     = 16'hFFFF;
  localparam logic [15:0] CrcPoly     = 16'hA001;

  // one result item
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data_byte;
    logic [7:0]  frame_type;
    logic [7:0]  seq_number;
    logic [15:0] payload_length;
  } result_t;

  // reflected crc-16/modbus over one byte, eight shift steps
  function automatic logic [15:0] crc16_upd(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

FILE: src/efd_if.sv
// interfaces: raw byte channel and result channel
`timescale 1ns / 1ps

interface efd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface efd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  data_byte;
  logic [7:0]  frame_type;
  logic [7:0]  seq_number;
  logic [15:0] payload_length;

  modport source (output valid, output kind, output data_byte, output frame_type,
                  output seq_number, output payload_length, input ready);
  modport sink (input valid, input kind, input data_byte, input frame_type,
                input seq_number, input payload_length, output ready);
endinterface

FILE: src/efd_parser.sv
// frame parser: phase state, header fields, escape decoding and running crc
`timescale 1ns / 1ps

module efd_parser
  import efd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  input  logic [7:0] start_marker_i,
  input  logic [7:0] escape_marker_i,
  output logic       res_valid_o,
  output result_t    res_o
);

  phase_e      phase_q, phase_d;
  logic        esc_q, esc_d;
  logic [7:0]  type_q, type_d;
  logic [7:0]  seq_q, seq_d;
  logic [15:0] len_q, len_d;
  logic [15:0] cnt_q, cnt_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  crc_lo_q, crc_lo_d;

  logic        literal;
  logic [15:0] cnt_inc;
  logic [15:0] crc_next;

  assign cnt_inc  = cnt_q + 16'd1;
  assign crc_next = crc16_upd(crc_q, byte_i);

  // next state and result
  always_comb begin
    phase_d  = phase_q;
    esc_d    = esc_q;
    type_d   = type_q;
    seq_d    = seq_q;
    len_d    = len_q;
    cnt_d    = cnt_q;
    crc_d    = crc_q;
    crc_lo_d = crc_lo_q;
    literal  = 1'b0;

    res_valid_o          = 1'b0;
    res_o.kind           = KIND_DATA;
    res_o.data_byte      = 8'h00;
    res_o.frame_type     = type_q;
    res_o.seq_number     = seq_q;
    res_o.payload_length = len_q;

    if (step_i) begin
      unique case (phase_q)
        PH_WAIT: begin
          if (byte_i == start_marker_i) begin
            phase_d = PH_TYPE;
            esc_d   = 1'b0;
            cnt_d   = 16'd0;
          end
        end
        PH_TYPE: begin
          type_d  = byte_i;
          crc_d   = crc16_upd(CrcInit, byte_i);
          phase_d = PH_SEQ;
        end
        PH_SEQ: begin
          seq_d   = byte_i;
          crc_d   = crc_next;
          phase_d = PH_LENLO;
        end
        PH_LENLO: begin
          len_d   = {8'h00, byte_i};
          crc_d   = crc_next;
          phase_d = PH_LENHI;
        end
        PH_LENHI: begin
          len_d   = {byte_i, len_q[7:0]};
          crc_d   = crc_next;
          cnt_d   = 16'd0;
          phase_d = ({byte_i, len_q[7:0]} == 16'd0) ? PH_CRCLO : PH_PAYLOAD;
        end
        default: begin
          // payload and crc bytes share escape decoding, escape tested first
          if (esc_q) begin
            esc_d   = 1'b0;
            literal = 1'b1;
          end else if (byte_i == escape_marker_i) begin
            esc_d = 1'b1;
          end else if (byte_i == start_marker_i) begin
            // resync: drop the frame and report it
            res_valid_o = 1'b1;
            res_o.kind  = KIND_ABORT;
            phase_d     = PH_TYPE;
            esc_d       = 1'b0;
            cnt_d       = 16'd0;
            crc_d       = CrcInit;
          end else begin
            literal = 1'b1;
          end

          if (literal) begin
            if (phase_q == PH_PAYLOAD) begin
              crc_d           = crc_next;
              cnt_d           = cnt_inc;
              res_valid_o     = 1'b1;
              res_o.kind      = KIND_DATA;
              res_o.data_byte = byte_i;
              if (cnt_inc == len_q) begin
                phase_d = PH_CRCLO;
              end
            end else if (phase_q == PH_CRCLO) begin
              crc_lo_d = byte_i;
              phase_d  = PH_CRCHI;
            end else begin
              res_valid_o = 1'b1;
              res_o.kind  = ({byte_i, crc_lo_q} == crc_q) ? KIND_GOOD : KIND_BAD;
              phase_d     = PH_WAIT;
              esc_d       = 1'b0;
            end
          end
        end
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_WAIT;
      esc_q    <= 1'b0;
      type_q   <= 8'h00;
      seq_q    <= 8'h00;
      len_q    <= 16'd0;
      cnt_q    <= 16'd0;
      crc_q    <= CrcInit;
      crc_lo_q <= 8'h00;
    end else begin
      phase_q  <= phase_d;
      esc_q    <= esc_d;
      type_q   <= type_d;
      seq_q    <= seq_d;
      len_q    <= len_d;
      cnt_q    <= cnt_d;
      crc_q    <= crc_d;
      crc_lo_q <= crc_lo_d;
    end
  end

endmodule

FILE: src/escaped_frame_deframer_crc16.sv
// top level: byte-stuffed frame receiver with crc-16/modbus check
//
//   channel   dir  handshake          payload
//   rx_i      in   valid/ready        rx_byte
//   res_o     out  valid/ready        kind, data_byte, frame_type, seq_number,
//                                     payload_length
//   cfg       in   cfg_we_i           cfg_idx_i, cfg_data_i
//
// one byte per cycle sustained while res_o is not stalled; each byte waits in the input register and
// its result (if any) is loaded into the result register as the byte leaves the input register
// the combinational byte crc update and the parser state registers form the feedback loop
// a stalled result register holds the input register, and rx_i.ready falls once both are full
// reset clears the parser to waiting for a start marker and the markers to 0xaa / 0xbb
`timescale 1ns / 1ps

module escaped_frame_deframer_crc16
  import efd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  efd_in_if.sink     rx_i,
  efd_out_if.source  res_o,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [7:0] cfg_data_i
);

  logic [7:0] start_q;
  logic [7:0] escape_q;

  logic       in_valid_q;
  logic [7:0] in_byte_q;

  logic       out_valid_q;
  result_t    out_q;

  logic       out_free;
  logic       step;
  logic       par_valid;
  result_t    par_res;

  assign out_free   = !out_valid_q || res_o.ready;
  assign step       = in_valid_q && out_free;
  assign rx_i.ready = !in_valid_q || out_free;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q  <= StartReset;
      escape_q <= EscapeReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_START:  start_q  <= cfg_data_i;
        CFG_ESCAPE: escape_q <= cfg_data_i;
        default:    start_q  <= start_q;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_i.ready) begin
      in_valid_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      in_byte_q <= rx_i.rx_byte;
    end
  end

  efd_parser u_parser (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (step),
    .byte_i          (in_byte_q),
    .start_marker_i  (start_q),
    .escape_marker_i (escape_q),
    .res_valid_o     (par_valid),
    .res_o           (par_res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= step && par_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && par_valid) begin
      out_q <= par_res;
    end
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.kind           = out_q.kind;
  assign res_o.data_byte      = out_q.data_byte;
  assign res_o.frame_type     = out_q.frame_type;
  assign res_o.seq_number     = out_q.seq_number;
  assign res_o.payload_length = out_q.payload_length;

endmodule

FILE: verif/tb_escaped_frame_deframer_crc16.sv
// testbench: byte-stuffed frame receiver, random framed traffic checked against a local predictor
`timescale 1ns / 1ps

module tb_escaped_frame_deframer_crc16;
  import efd_pkg::*;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic       cfg_idx_i;
  logic [7:0] cfg_data_i;

  efd_in_if  rx_ch ();
  efd_out_if res_ch ();

  escaped_frame_deframer_crc16 DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_i       (rx_ch),
    .res_o      (res_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // link bytes waiting to be sent, decoded results still owed by the block
  logic [7:0] link_bytes[$];
  logic [7:0] frame_payload[$];
  result_t    due_results[$];
  result_t    res_want;
  int         bytes_queued;
  int         mismatches;
  int         rx_gap;
  int         res_gap;
  bit         rx_took;
  bit         calm;

  // predictor copy of the markers and the parser state
  logic [7:0]  start_mark;
  logic [7:0]  esc_mark;
  phase_e      ph;
  logic        esc_armed;
  logic [7:0]  hdr_type;
  logic [7:0]  hdr_seq;
  logic [15:0] hdr_len;
  logic [15:0] pay_seen;
  logic [15:0] crc_acc;
  logic [7:0]  crc_lo_rx;

  // reflected modbus crc, one byte
  function automatic logic [15:0] modbus_crc_step(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] r;
    r = acc ^ {8'h00, b};
    repeat (8) r = r[0] ? ((r >> 1) ^ CrcPoly) : (r >> 1);
    return r;
  endfunction

  task automatic owe_result(input kind_e k, input logic [7:0] d);
    result_t r;
    r.kind           = k;
    r.data_byte      = d;
    r.frame_type     = hdr_type;
    r.seq_number     = hdr_seq;
    r.payload_length = hdr_len;
    due_results.insert(due_results.size(), r);
  endtask

  // parse one link byte, queue the result it causes
  task automatic deframe_byte(input logic [7:0] b);
    logic literal;
    literal = 1'b0;
    case (ph)
      PH_WAIT: begin
        if (b == start_mark) begin
          ph        = PH_TYPE;
          esc_armed = 1'b0;
          pay_seen  = '0;
        end
      end
      PH_TYPE: begin
        hdr_type = b;
        crc_acc  = modbus_crc_step(CrcInit, b);
        ph       = PH_SEQ;
      end
      PH_SEQ: begin
        hdr_seq = b;
        crc_acc = modbus_crc_step(crc_acc, b);
        ph      = PH_LENLO;
      end
      PH_LENLO: begin
        hdr_len = {8'h00, b};
        crc_acc = modbus_crc_step(crc_acc, b);
        ph      = PH_LENHI;
      end
      PH_LENHI: begin
        hdr_len[15:8] = b;
        crc_acc       = modbus_crc_step(crc_acc, b);
        pay_seen      = '0;
        ph            = (hdr_len == 16'd0) ? PH_CRCLO : PH_PAYLOAD;
      end
      default: begin
        // escape wins over start when both markers match
        if (esc_armed) begin
          esc_armed = 1'b0;
          literal   = 1'b1;
        end else if (b == esc_mark) begin
          esc_armed = 1'b1;
        end else if (b == start_mark) begin
          owe_result(KIND_ABORT, 8'h00);
          ph        = PH_TYPE;
          esc_armed = 1'b0;
          pay_seen  = '0;
          crc_acc   = CrcInit;
        end else begin
          literal = 1'b1;
        end
        if (literal) begin
          if (ph == PH_PAYLOAD) begin
            crc_acc  = modbus_crc_step(crc_acc, b);
            pay_seen = pay_seen + 16'd1;
            owe_result(KIND_DATA, b);
            if (pay_seen == hdr_len) ph = PH_CRCLO;
          end else if (ph == PH_CRCLO) begin
            crc_lo_rx = b;
            ph        = PH_CRCHI;
          end else begin
            owe_result(({b, crc_lo_rx} == crc_acc) ? KIND_GOOD : KIND_BAD, 8'h00);
            ph        = PH_WAIT;
            esc_armed = 1'b0;
          end
        end
      end
    endcase
  endtask

  // byte biased towards markers and extremes
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return start_mark;
      1:       return esc_mark;
      2:       return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      default: return 8'($urandom);
    endcase
  endfunction

  // build one frame; cut_at > 0 keeps that many bytes, < 0 cuts at random after the header
  task automatic queue_frame(input logic [7:0] ftype, input logic [7:0] fseq,
                             input logic [15:0] flen, input int cut_at, input bit spoil_crc);
    logic [7:0]  frame_bytes[$];
    logic [7:0]  plain[$];
    logic [15:0] crc;
    logic [7:0]  pb;
    int          keep;
    frame_bytes = {start_mark, ftype, fseq, flen[7:0], flen[15:8]};
    crc = CrcInit;
    for (int i = 1; i < 5; i++) crc = modbus_crc_step(crc, frame_bytes[i]);
    for (int i = 0; i < int'(flen); i++) begin
      pb  = (i < frame_payload.size()) ? frame_payload[i] : pick_byte();
      crc = modbus_crc_step(crc, pb);
      plain.insert(plain.size(), pb);
    end
    if (spoil_crc) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
    plain.insert(plain.size(), crc[7:0]);
    plain.insert(plain.size(), crc[15:8]);
    // markers are always escaped, other bytes now and then
    foreach (plain[i]) begin
      if (plain[i] == start_mark || plain[i] == esc_mark || $urandom_range(0, 7) == 0)
        frame_bytes.insert(frame_bytes.size(), esc_mark);
      frame_bytes.insert(frame_bytes.size(), plain[i]);
    end
    keep = frame_bytes.size();
    if (cut_at > 0 && cut_at < keep) keep = cut_at;
    else if (cut_at < 0) keep = $urandom_range(5, frame_bytes.size() - 1);
    for (int i = 0; i < keep; i++) link_bytes.insert(link_bytes.size(), frame_bytes[i]);
    bytes_queued += keep;
    frame_payload.delete();
  endtask

  // mostly well-formed frames, some spoilt, cut short or with line noise between
  task automatic random_traffic(input int upto, input bit allow_cut);
    logic [15:0] flen;
    logic [7:0]  pb;
    int          pick;
    while (bytes_queued < upto) begin
      if ($urandom_range(0, 19) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          pb = 8'($urandom);
          if (pb == start_mark) pb = ~pb;
          link_bytes.insert(link_bytes.size(), pb);
        end
      end else begin
        pick = $urandom_range(0, 19);
        if (pick < 14)      flen = 16'($urandom_range(0, 8));
        else if (pick < 19) flen = 16'($urandom_range(9, 40));
        else                flen = 16'($urandom_range(41, 300));
        queue_frame(($urandom_range(0, 5) == 0) ? start_mark : 8'($urandom),
                    ($urandom_range(0, 5) == 0) ? esc_mark : 8'($urandom),
                    flen, (allow_cut && $urandom_range(0, 9) == 0) ? -1 : 0,
                    $urandom_range(0, 6) == 0);
      end
    end
  endtask

  // wait until every byte is taken and every result is in, then let the pipe empty
  task automatic drain_all();
    while (link_bytes.size() != 0 || due_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_markers(input logic [7:0] sm, input logic [7:0] em);
    drain_all();
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_START;
    cfg_data_i <= sm;
    @(negedge clk_i);
    cfg_idx_i  <= CFG_ESCAPE;
    cfg_data_i <= em;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    start_mark = sm;
    esc_mark   = em;
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #3_000_000;
    $display("FAIL");
    $finish;
  end

  // byte driver: note taken items, then present the next one at the falling edge
  always @(posedge clk_i) begin
    rx_took = 1'b0;
    if (rst_ni && rx_ch.valid && rx_ch.ready) begin
      rx_took = 1'b1;
      deframe_byte(rx_ch.rx_byte);
      void'(link_bytes.pop_front());
    end
  end

  always @(negedge clk_i) begin
    if (rx_ch.valid && !rx_took) begin
      // hold the item until it is taken
    end else if (rx_gap != 0) begin
      rx_gap = rx_gap - 1;
      rx_ch.valid <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      rx_gap = $urandom_range(0, 15);
      rx_ch.valid <= 1'b0;
    end else if (link_bytes.size() != 0) begin
      rx_ch.valid   <= 1'b1;
      rx_ch.rx_byte <= link_bytes[0];
    end else begin
      rx_ch.valid <= 1'b0;
    end
  end

  // result monitor: compare with the oldest owed result
  always @(posedge clk_i) begin
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (due_results.size() == 0) begin
        $error("result with none owed: kind %0d", res_ch.kind);
        mismatches++;
      end else begin
        res_want = due_results.pop_front();
        check_field("kind", res_want.kind, res_ch.kind);
        check_field("data_byte", res_want.data_byte, res_ch.data_byte);
        check_field("frame_type", res_want.frame_type, res_ch.frame_type);
        check_field("seq_number", res_want.seq_number, res_ch.seq_number);
        check_field("payload_length", res_want.payload_length, res_ch.payload_length);
      end
    end
  end

  // receiver stalls
  always @(negedge clk_i) begin
    if (res_gap != 0) begin
      res_gap = res_gap - 1;
      res_ch.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      res_gap = $urandom_range(0, 15);
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  // stimulus and verdict
  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_START;
    cfg_data_i    = 8'h00;
    rx_ch.valid   = 1'b0;
    rx_ch.rx_byte = 8'h00;
    res_ch.ready  = 1'b0;
    rx_took       = 1'b0;
    rx_gap        = 0;
    res_gap       = 0;
    calm          = 1'b0;
    mismatches    = 0;
    bytes_queued  = 0;
    start_mark    = StartReset;
    esc_mark      = EscapeReset;
    ph            = PH_WAIT;
    esc_armed     = 1'b0;
    hdr_type      = '0;
    hdr_seq       = '0;
    hdr_len       = '0;
    pay_seen      = '0;
    crc_acc       = CrcInit;
    crc_lo_rx     = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: idle noise, raw markers in header with empty payload
    link_bytes.insert(link_bytes.size(), 8'h00);
    link_bytes.insert(link_bytes.size(), 8'hFF);
    queue_frame(start_mark, esc_mark, 16'd0, 0, 1'b0);
    // escaped markers and extremes in payload
    frame_payload = {start_mark, esc_mark, 8'h00, 8'hFF};
    queue_frame(8'h01, 8'h80, 16'd4, 0, 1'b0);
    // largest length, resync at first payload byte
    queue_frame(8'hFF, 8'h00, 16'hFFFF, 5, 1'b0);
    // resync while waiting for the crc
    queue_frame(8'h55, 8'h66, 16'd0, 5, 1'b0);
    // crc mismatch
    frame_payload = {8'h7F};
    queue_frame(8'h12, 8'h34, 16'd1, 0, 1'b1);

    random_traffic(600, 1'b1);
    write_markers(8'h00, 8'hFF);
    random_traffic(950, 1'b1);
    // equal markers: the start value only escapes inside a frame, so no cut frames
    write_markers(8'h7E, 8'h7E);
    random_traffic(1250, 1'b0);
    write_markers(8'hFF, 8'h00);
    random_traffic(1500, 1'b1);
    write_markers(8'h55, 8'h5A);
    calm = 1'b1;
    random_traffic(1750, 1'b1);

    drain_all();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
